// ===== rtl/core/calendar_time_setter_unit_macros.svh =====
// Assertion macros shared by the calendar time setter RTL.
`ifndef CALENDAR_TIME_SETTER_UNIT_MACROS_SVH
`define CALENDAR_TIME_SETTER_UNIT_MACROS_SVH

`ifndef SYNTH

// Invariant checked at every clock edge outside reset.
`define CTS_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("cts invariant failed");

// Same-cycle implication.
`define CTS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cts implication failed");

// Next-cycle implication.
`define CTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cts next-cycle check failed");

`else

`define CTS_ASSERT(label, cond)
`define CTS_ASSERT_IMPL(label, ante, cons)
`define CTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/cts_pkg.sv =====
// Types, codes, constants and helpers for the calendar time setter.
package cts_pkg;

	localparam int unsigned DEF_QUEUE_DEPTH = 2;

	localparam logic [15:0] BLINK_RESET = 16'd500;

	// action codes
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_KEY  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// key codes
	localparam logic [2:0] KEY_MODE   = 3'd1;
	localparam logic [2:0] KEY_SELECT = 3'd2;
	localparam logic [2:0] KEY_UP     = 3'd3;
	localparam logic [2:0] KEY_DOWN   = 3'd4;

	// field indexes
	localparam logic [2:0] FLD_YEAR   = 3'd0;
	localparam logic [2:0] FLD_MONTH  = 3'd1;
	localparam logic [2:0] FLD_DAY    = 3'd2;
	localparam logic [2:0] FLD_HOUR   = 3'd3;
	localparam logic [2:0] FLD_MINUTE = 3'd4;
	localparam logic [2:0] FLD_SECOND = 3'd5;

	localparam logic [6:0] YEAR_MAX   = 7'd99;
	localparam logic [3:0] MONTH_MAX  = 4'd12;
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINSEC_MAX = 6'd59;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_MODE,
		OP_SELECT,
		OP_UP,
		OP_DOWN,
		OP_LOAD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} entry_t;

	typedef struct packed {
		logic   en;
		entry_t data;
	} qwr_t;

	// Last day of the month; leap February on years divisible by four.
	function automatic logic [4:0] day_limit(input logic [6:0] year, input logic [3:0] month);
		logic [4:0] lim;
		case (month)
			4'd4, 4'd6, 4'd9, 4'd11: lim = 5'd30;
			4'd2:                    lim = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default:                 lim = 5'd31;
		endcase
		return lim;
	endfunction

endpackage

// ===== rtl/core/cts_front.sv =====
// Front end: accepts items and decodes them into queue operations.
module cts_front (
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    action,
	input  logic [2:0]    key_code,
	input  logic [6:0]    year_in,
	input  logic [3:0]    month_in,
	input  logic [4:0]    day_in,
	input  logic [4:0]    hour_in,
	input  logic [5:0]    minute_in,
	input  logic [5:0]    second_in,
	input  logic          q_full,
	output cts_pkg::qwr_t q_wr
);
	import cts_pkg::*;

	op_t op;

	always_comb begin
		case (action)
			ACT_TICK: op = OP_TICK;
			ACT_KEY: begin
				case (key_code)
					KEY_MODE:   op = OP_MODE;
					KEY_SELECT: op = OP_SELECT;
					KEY_UP:     op = OP_UP;
					KEY_DOWN:   op = OP_DOWN;
					default:    op = OP_NONE;
				endcase
			end
			ACT_READ: op = OP_LOAD;
			default:  op = OP_NONE;
		endcase
	end

	assign in_ready = !q_full;

	always_comb begin
		q_wr.en          = in_valid && !q_full;
		q_wr.data.op     = op;
		q_wr.data.year   = year_in;
		q_wr.data.month  = month_in;
		q_wr.data.day    = day_in;
		q_wr.data.hour   = hour_in;
		q_wr.data.minute = minute_in;
		q_wr.data.second = second_in;
	end

endmodule

// ===== rtl/core/cts_queue.sv =====
// Short FIFO between the front end and the update engine.
`include "calendar_time_setter_unit_macros.svh"

module cts_queue #(
	parameter int unsigned Depth = cts_pkg::DEF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cts_pkg::qwr_t   wr,
	output logic            full,
	output logic            rd_valid,
	output cts_pkg::entry_t rd_data,
	input  logic            rd_en
);
	import cts_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	entry_t          mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == DepthCnt);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.en) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr.en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CTS_ASSERT(a_count_bound, count_q <= DepthCnt)
	`CTS_ASSERT_IMPL(a_no_read_empty, rd_en, count_q != '0)
	`CTS_ASSERT_NEXT(a_push_counts, wr.en && !rd_en, count_q == CntW'($past(count_q) + 1'b1))

endmodule

// ===== rtl/core/cts_back.sv =====
// Update engine: applies queued items to the calendar state and holds the result.
`include "calendar_time_setter_unit_macros.svh"

module cts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [15:0]     cfg_wr_data,
	input  logic            q_valid,
	input  cts_pkg::entry_t q_entry,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            set_mode,
	output logic [2:0]      selected_field,
	output logic            blink_on,
	output logic [6:0]      year_out,
	output logic [3:0]      month_out,
	output logic [4:0]      day_out,
	output logic [4:0]      hour_out,
	output logic [5:0]      minute_out,
	output logic [5:0]      second_out,
	output logic            write_clock
);
	import cts_pkg::*;

	logic [15:0] half_period_q;
	logic        mode_q, mode_d;
	logic [2:0]  sel_q, sel_d;
	logic        blink_q, blink_d;
	logic [15:0] tick_q, tick_d;
	logic [6:0]  year_q, year_d;
	logic [3:0]  month_q, month_d;
	logic [4:0]  day_q, day_d;
	logic [4:0]  hour_q, hour_d;
	logic [5:0]  minute_q, minute_d;
	logic [5:0]  second_q, second_d;
	logic        out_valid_q;
	logic        write_clock_q, wc_d;

	logic [15:0] tick_inc;
	logic [6:0]  cur_v, lo_v, hi_v, up_v, dn_v, new_v;
	logic [6:0]  s_year;
	logic [3:0]  s_month;
	logic [4:0]  s_day, s_hour;
	logic [5:0]  s_minute, s_second;
	logic [6:0]  n_year;
	logic [3:0]  n_month;
	logic [4:0]  n_day, n_hour, n_lim;
	logic [5:0]  n_minute, n_second;

	// The state registers are the result payload; a new item is taken only
	// when the held result is gone or leaving.
	assign q_pop = q_valid && (!out_valid_q || out_ready);

	// Selected field value and its bounds.
	always_comb begin
		case (sel_q)
			FLD_MONTH: begin
				cur_v = {3'b0, month_q};
				lo_v  = 7'd1;
				hi_v  = {3'b0, MONTH_MAX};
			end
			FLD_DAY: begin
				cur_v = {2'b0, day_q};
				lo_v  = 7'd1;
				hi_v  = {2'b0, day_limit(year_q, month_q)};
			end
			FLD_HOUR: begin
				cur_v = {2'b0, hour_q};
				lo_v  = 7'd0;
				hi_v  = {2'b0, HOUR_MAX};
			end
			FLD_MINUTE: begin
				cur_v = {1'b0, minute_q};
				lo_v  = 7'd0;
				hi_v  = {1'b0, MINSEC_MAX};
			end
			FLD_SECOND: begin
				cur_v = {1'b0, second_q};
				lo_v  = 7'd0;
				hi_v  = {1'b0, MINSEC_MAX};
			end
			default: begin
				cur_v = year_q;
				lo_v  = 7'd0;
				hi_v  = YEAR_MAX;
			end
		endcase
	end

	assign up_v  = (cur_v >= hi_v) ? lo_v : cur_v + 7'd1;
	assign dn_v  = (cur_v <= lo_v || cur_v > hi_v) ? hi_v : cur_v - 7'd1;
	assign new_v = (q_entry.op == OP_UP) ? up_v : dn_v;

	always_comb begin
		s_year   = (sel_q == FLD_YEAR)   ? new_v       : year_q;
		s_month  = (sel_q == FLD_MONTH)  ? new_v[3:0]  : month_q;
		s_day    = (sel_q == FLD_DAY)    ? new_v[4:0]  : day_q;
		s_hour   = (sel_q == FLD_HOUR)   ? new_v[4:0]  : hour_q;
		s_minute = (sel_q == FLD_MINUTE) ? new_v[5:0]  : minute_q;
		s_second = (sel_q == FLD_SECOND) ? new_v[5:0]  : second_q;
		// sel_q never leaves 0..5; anything else behaves as the year
		if (sel_q > FLD_SECOND) begin
			s_year = new_v;
		end
	end

	// Pull every field back into range; the day limit uses the fixed year and month.
	always_comb begin
		n_year   = (s_year > YEAR_MAX) ? 7'd0 : s_year;
		n_month  = (s_month == 4'd0 || s_month > MONTH_MAX) ? 4'd1 : s_month;
		n_lim    = day_limit(n_year, n_month);
		n_day    = (s_day == 5'd0 || s_day > n_lim) ? 5'd1 : s_day;
		n_hour   = (s_hour > HOUR_MAX) ? 5'd0 : s_hour;
		n_minute = (s_minute > MINSEC_MAX) ? 6'd0 : s_minute;
		n_second = (s_second > MINSEC_MAX) ? 6'd0 : s_second;
	end

	assign tick_inc = tick_q + 16'd1;

	always_comb begin
		mode_d   = mode_q;
		sel_d    = sel_q;
		blink_d  = blink_q;
		tick_d   = tick_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		wc_d     = 1'b0;
		case (q_entry.op)
			OP_TICK: begin
				if (tick_inc >= half_period_q) begin
					tick_d  = '0;
					blink_d = !blink_q;
				end else begin
					tick_d = tick_inc;
				end
			end
			OP_MODE: begin
				if (!mode_q) begin
					mode_d = 1'b1;
					sel_d  = FLD_YEAR;
				end else begin
					mode_d = 1'b0;
					wc_d   = 1'b1;
				end
			end
			OP_SELECT: begin
				if (mode_q) begin
					sel_d = (sel_q >= FLD_SECOND) ? FLD_YEAR : sel_q + 3'd1;
				end
			end
			OP_UP, OP_DOWN: begin
				if (mode_q) begin
					year_d   = n_year;
					month_d  = n_month;
					day_d    = n_day;
					hour_d   = n_hour;
					minute_d = n_minute;
					second_d = n_second;
				end
			end
			OP_LOAD: begin
				// readings load raw, no range fix
				if (!mode_q) begin
					year_d   = q_entry.year;
					month_d  = q_entry.month;
					day_d    = q_entry.day;
					hour_d   = q_entry.hour;
					minute_d = q_entry.minute;
					second_d = q_entry.second;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= BLINK_RESET;
		end else if (cfg_wr_en) begin
			half_period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			sel_q         <= FLD_YEAR;
			blink_q       <= 1'b0;
			tick_q        <= '0;
			year_q        <= 7'd0;
			month_q       <= 4'd1;
			day_q         <= 5'd1;
			hour_q        <= 5'd0;
			minute_q      <= 6'd0;
			second_q      <= 6'd0;
			out_valid_q   <= 1'b0;
			write_clock_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mode_q        <= mode_d;
				sel_q         <= sel_d;
				blink_q       <= blink_d;
				tick_q        <= tick_d;
				year_q        <= year_d;
				month_q       <= month_d;
				day_q         <= day_d;
				hour_q        <= hour_d;
				minute_q      <= minute_d;
				second_q      <= second_d;
				write_clock_q <= wc_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign set_mode       = mode_q;
	assign selected_field = sel_q;
	assign blink_on       = blink_q && mode_q;
	assign year_out       = year_q;
	assign month_out      = month_q;
	assign day_out        = day_q;
	assign hour_out       = hour_q;
	assign minute_out     = minute_q;
	assign second_out     = second_q;
	assign write_clock    = write_clock_q;

	`CTS_ASSERT_IMPL(a_wc_leaves_set, out_valid_q && write_clock_q, !mode_q)
	`CTS_ASSERT(a_sel_range, sel_q <= FLD_SECOND)
	`CTS_ASSERT_NEXT(a_enter_set, q_pop && q_entry.op == OP_MODE && !mode_q, mode_q && sel_q == FLD_YEAR)

endmodule

// ===== rtl/core/calendar_time_setter_unit.sv =====
// Top level of the calendar time setter: front end, queue and update engine.
//
// Each item (tick, key press or clock chip reading) yields exactly one result
// carrying the full calendar state after that item. Items are accepted one
// per cycle while the queue has room; the queue holds QueueDepth items
// (default 2). An accepted item is written into the queue and then applied by
// the update engine, whose calendar registers double as the result register.
// The sustained rate is one item per cycle while each result is taken. A
// result that is not taken holds the engine; the queue then fills and in_ready
// drops until the result leaves. The blink period register may be written at
// any time the block is idle.
module calendar_time_setter_unit #(
	parameter int unsigned QueueDepth = cts_pkg::DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [2:0]  key_code,
	input  logic [6:0]  year_in,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [4:0]  hour_in,
	input  logic [5:0]  minute_in,
	input  logic [5:0]  second_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        set_mode,
	output logic [2:0]  selected_field,
	output logic        blink_on,
	output logic [6:0]  year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out,
	output logic        write_clock
);
	import cts_pkg::*;

	qwr_t   q_wr;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;

	cts_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.key_code  (key_code),
		.year_in   (year_in),
		.month_in  (month_in),
		.day_in    (day_in),
		.hour_in   (hour_in),
		.minute_in (minute_in),
		.second_in (second_in),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	cts_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_data  (q_entry),
		.rd_en    (q_pop)
	);

	cts_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.q_valid        (q_valid),
		.q_entry        (q_entry),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.set_mode       (set_mode),
		.selected_field (selected_field),
		.blink_on       (blink_on),
		.year_out       (year_out),
		.month_out      (month_out),
		.day_out        (day_out),
		.hour_out       (hour_out),
		.minute_out     (minute_out),
		.second_out     (second_out),
		.write_clock    (write_clock)
	);

endmodule

// ===== tb/tb_calendar_time_setter_unit.sv =====
// Self-checking testbench for the calendar time setter: directed and random items.
`timescale 1ns / 100ps

module tb_calendar_time_setter_unit;
	import cts_pkg::*;

	// codes the block treats as no-ops
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam logic [2:0] KEY_NONE  = 3'd0;
	localparam logic [2:0] KEY_LAST  = 3'd7;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] key;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} cal_stim_t;

	// field order matches the output port concatenation in the checker
	typedef struct packed {
		logic       mode;
		logic [2:0] sel;
		logic       blink;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       wr_clock;
	} cal_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [2:0]  key_code;
	logic [6:0]  year_in;
	logic [3:0]  month_in;
	logic [4:0]  day_in;
	logic [4:0]  hour_in;
	logic [5:0]  minute_in;
	logic [5:0]  second_in;
	logic        out_valid;
	logic        out_ready;
	logic        set_mode;
	logic [2:0]  selected_field;
	logic        blink_on;
	logic [6:0]  year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [5:0]  second_out;
	logic        write_clock;

	// shadow calendar state
	logic        cal_mode;
	logic [2:0]  cal_sel;
	logic        cal_blink;
	logic [15:0] cal_ticks;
	logic [15:0] cal_half;
	logic [6:0]  cal_fld [0:5];

	cal_result_t pending_results[$];
	int mismatch_cnt;
	int result_cnt;
	int tick_cnt, key_cnt, read_cnt, other_cnt, strobe_cnt, setting_cnt;

	calendar_time_setter_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.key_code       (key_code),
		.year_in        (year_in),
		.month_in       (month_in),
		.day_in         (day_in),
		.hour_in        (hour_in),
		.minute_in      (minute_in),
		.second_in      (second_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.set_mode       (set_mode),
		.selected_field (selected_field),
		.blink_on       (blink_on),
		.year_out       (year_out),
		.month_out      (month_out),
		.day_out        (day_out),
		.hour_out       (hour_out),
		.minute_out     (minute_out),
		.second_out     (second_out),
		.write_clock    (write_clock)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_calendar_time_setter_unit NOT OK");
		$finish;
	end

	function automatic logic [6:0] days_in_month(input logic [6:0] yr, input logic [6:0] mo);
		if (mo == 7'd4 || mo == 7'd6 || mo == 7'd9 || mo == 7'd11)
			return 7'd30;
		if (mo == 7'd2)
			return (yr[1:0] == 2'b00) ? 7'd29 : 7'd28;
		return 7'd31;
	endfunction

	// Applies one item to the shadow state and returns the result it must produce.
	function automatic cal_result_t advance_calendar(input cal_stim_t s);
		cal_result_t r;
		logic        strobe;
		logic [6:0]  lo, hi, v;
		strobe = 1'b0;
		case (s.action)
			ACT_TICK: begin
				cal_ticks = cal_ticks + 16'd1;
				if (cal_ticks >= cal_half) begin
					cal_ticks = '0;
					cal_blink = ~cal_blink;
				end
			end
			ACT_KEY: begin
				if (s.key == KEY_MODE) begin
					if (!cal_mode) begin
						cal_mode = 1'b1;
						cal_sel = FLD_YEAR;
					end else begin
						cal_mode = 1'b0;
						strobe = 1'b1;
					end
				end else if (cal_mode && s.key == KEY_SELECT) begin
					cal_sel = (cal_sel == FLD_SECOND) ? FLD_YEAR : cal_sel + 3'd1;
				end else if (cal_mode && (s.key == KEY_UP || s.key == KEY_DOWN)) begin
					lo = (cal_sel == FLD_MONTH || cal_sel == FLD_DAY) ? 7'd1 : 7'd0;
					case (cal_sel)
						FLD_YEAR:  hi = YEAR_MAX;
						FLD_MONTH: hi = {3'd0, MONTH_MAX};
						FLD_DAY:   hi = days_in_month(cal_fld[FLD_YEAR], cal_fld[FLD_MONTH]);
						FLD_HOUR:  hi = {2'd0, HOUR_MAX};
						default:   hi = {1'b0, MINSEC_MAX};
					endcase
					v = cal_fld[cal_sel];
					if (s.key == KEY_UP)
						v = (v >= hi) ? lo : v + 7'd1;
					else
						v = (v <= lo || v > hi) ? hi : v - 7'd1;
					cal_fld[cal_sel] = v;
					// clean up every field, in order, after the step
					if (cal_fld[FLD_YEAR] > YEAR_MAX)
						cal_fld[FLD_YEAR] = 7'd0;
					if (cal_fld[FLD_MONTH] == 7'd0 || cal_fld[FLD_MONTH] > MONTH_MAX)
						cal_fld[FLD_MONTH] = 7'd1;
					if (cal_fld[FLD_DAY] == 7'd0 ||
							cal_fld[FLD_DAY] > days_in_month(cal_fld[FLD_YEAR], cal_fld[FLD_MONTH]))
						cal_fld[FLD_DAY] = 7'd1;
					if (cal_fld[FLD_HOUR] > HOUR_MAX)
						cal_fld[FLD_HOUR] = 7'd0;
					if (cal_fld[FLD_MINUTE] > MINSEC_MAX)
						cal_fld[FLD_MINUTE] = 7'd0;
					if (cal_fld[FLD_SECOND] > MINSEC_MAX)
						cal_fld[FLD_SECOND] = 7'd0;
				end
			end
			ACT_READ: begin
				if (!cal_mode) begin
					cal_fld[FLD_YEAR]   = s.year;
					cal_fld[FLD_MONTH]  = {3'd0, s.month};
					cal_fld[FLD_DAY]    = {2'd0, s.day};
					cal_fld[FLD_HOUR]   = {2'd0, s.hour};
					cal_fld[FLD_MINUTE] = {1'b0, s.minute};
					cal_fld[FLD_SECOND] = {1'b0, s.second};
				end
			end
			default: ;
		endcase
		r.mode     = cal_mode;
		r.sel      = cal_sel;
		r.blink    = cal_blink & cal_mode;
		r.year     = cal_fld[FLD_YEAR];
		r.month    = cal_fld[FLD_MONTH][3:0];
		r.day      = cal_fld[FLD_DAY][4:0];
		r.hour     = cal_fld[FLD_HOUR][4:0];
		r.minute   = cal_fld[FLD_MINUTE][5:0];
		r.second   = cal_fld[FLD_SECOND][5:0];
		r.wr_clock = strobe;
		return r;
	endfunction

	// item with random data fields
	function automatic cal_stim_t press(input logic [1:0] act, input logic [2:0] key);
		cal_stim_t s;
		s.action = act;
		s.key    = key;
		s.year   = 7'($urandom);
		s.month  = 4'($urandom);
		s.day    = 5'($urandom);
		s.hour   = 5'($urandom);
		s.minute = 6'($urandom);
		s.second = 6'($urandom);
		return s;
	endfunction

	function automatic cal_stim_t reading(input logic [6:0] yr, input logic [3:0] mo,
			input logic [4:0] dy, input logic [4:0] hr, input logic [5:0] mi, input logic [5:0] se);
		cal_stim_t s;
		s = press(ACT_READ, 3'($urandom));
		s.year   = yr;
		s.month  = mo;
		s.day    = dy;
		s.hour   = hr;
		s.minute = mi;
		s.second = se;
		return s;
	endfunction

	task automatic send_item(input cal_stim_t s);
		action    <= s.action;
		key_code  <= s.key;
		year_in   <= s.year;
		month_in  <= s.month;
		day_in    <= s.day;
		hour_in   <= s.hour;
		minute_in <= s.minute;
		second_in <= s.second;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(advance_calendar(s));
		case (s.action)
			ACT_TICK: tick_cnt++;
			ACT_KEY:  key_cnt++;
			ACT_READ: read_cnt++;
			default:  other_cnt++;
		endcase
		if (pending_results[$].wr_clock)
			strobe_cnt++;
	endtask

	task automatic sender_pause(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// blink period written only with the block idle
	task automatic set_blink_period(input logic [15:0] half);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= half;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cal_half = half;
		setting_cnt++;
	endtask

	task automatic test_clock_readings();
		send_item(reading(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
		send_item(reading(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0));
		// all ones, out of range, loads as given
		send_item(reading(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
	endtask

	task automatic test_keys_in_show_mode();
		send_item(press(ACT_KEY, KEY_SELECT));
		send_item(press(ACT_KEY, KEY_UP));
		send_item(press(ACT_KEY, KEY_DOWN));
		send_item(press(ACT_KEY, KEY_NONE));
		send_item(press(ACT_KEY, KEY_LAST));
		send_item(press(ACT_SPARE, KEY_MODE));
	endtask

	task automatic test_set_mode_walk();
		send_item(press(ACT_KEY, KEY_MODE));
		send_item(press(ACT_KEY, KEY_UP));      // year wraps, bad fields cleaned
		send_item(press(ACT_KEY, KEY_DOWN));    // year 0 -> 99
		send_item(reading(7'd5, 4'd5, 5'd5, 5'd5, 6'd5, 6'd5));
		send_item(press(ACT_KEY, KEY_SELECT));
		send_item(press(ACT_KEY, KEY_DOWN));
		send_item(press(ACT_KEY, KEY_UP));
		send_item(press(ACT_KEY, KEY_SELECT));
		send_item(press(ACT_KEY, KEY_DOWN));
		repeat (3) send_item(press(ACT_KEY, KEY_SELECT));
		send_item(press(ACT_KEY, KEY_DOWN));
		send_item(press(ACT_KEY, KEY_SELECT)); // selection wraps to year
		send_item(press(ACT_KEY, KEY_MODE));   // leave: write strobe
	endtask

	task automatic test_leap_february();
		send_item(reading(7'd4, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30));
		send_item(press(ACT_KEY, KEY_MODE));
		repeat (2) send_item(press(ACT_KEY, KEY_SELECT));
		send_item(press(ACT_KEY, KEY_UP));
		send_item(press(ACT_KEY, KEY_DOWN));
		send_item(press(ACT_KEY, KEY_MODE));
		send_item(press(ACT_KEY, KEY_MODE));
		send_item(press(ACT_KEY, KEY_UP));      // year 5: day 29 falls back to 1
	endtask

	task automatic test_random_sessions();
		cal_stim_t s;
		logic [15:0] half;
		int phase, done, burst_left, r;
		logic ignored;
		burst_left = 0;
		for (phase = 0; phase < 7; phase++) begin
			case (phase)
				0:       half = 16'd1;
				1:       half = 16'd0;
				2:       half = 16'd65535;
				3:       half = 16'd2;
				4:       half = 16'($urandom_range(3, 12));
				5:       half = BLINK_RESET;
				default: half = 16'($urandom_range(1, 65535));
			endcase
			set_blink_period(half);
			done = 0;
			while (done < 190) begin
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(30, 60);
					end else begin
						sender_pause($urandom_range(1, 6));
						burst_left = $urandom_range(1, 20);
					end
				end
				burst_left--;
				r = $urandom_range(0, 99);
				if (!cal_mode) begin
					if (r < 25)
						s = press(ACT_KEY, KEY_MODE);
					else if (r < 50)
						s = reading(7'($urandom_range(0, 99)), 4'($urandom_range(1, 12)),
							5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
							6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
					else if (r < 60)
						s = press(ACT_READ, 3'($urandom));
					else if (r < 85)
						s = press(ACT_TICK, 3'($urandom));
					else
						s = press(2'($urandom), 3'($urandom));
				end else begin
					if (r < 6)
						s = press(ACT_KEY, KEY_MODE);
					else if (r < 30)
						s = press(ACT_KEY, KEY_SELECT);
					else if (r < 55)
						s = press(ACT_KEY, KEY_UP);
					else if (r < 80)
						s = press(ACT_KEY, KEY_DOWN);
					else if (r < 92)
						s = press(ACT_TICK, 3'($urandom));
					else
						s = press(2'($urandom), 3'($urandom));
				end
				ignored = (s.action == ACT_SPARE) || (s.action == ACT_READ && cal_mode) ||
					(s.action == ACT_KEY && s.key != KEY_MODE &&
					(!cal_mode || s.key == KEY_NONE || s.key > KEY_DOWN));
				send_item(s);
				if (!ignored)
					done++;
			end
		end
	endtask

	// receiver: ready pattern picks a new random style after each random span
	initial begin : ready_pattern
		int style, span, k;
		@(posedge arst_n);
		forever begin
			style = $urandom_range(0, 3);
			span = $urandom_range(16, 80);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				case (style)
					0:       out_ready <= 1'b1;
					1:       out_ready <= ($urandom_range(0, 3) != 0);
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (k % 7 == 6);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		cal_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {set_mode, selected_field, blink_on, year_out, month_out, day_out,
				hour_out, minute_out, second_out, write_clock};
			result_cnt++;
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result with no item pending: %h", $realtime, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("%0t: result %0d mismatch", $realtime, result_cnt);
						$display("  expected mode %0d sel %0d blink %0d %0d-%0d-%0d %0d:%0d:%0d wr %0d",
							want.mode, want.sel, want.blink, want.year, want.month, want.day,
							want.hour, want.minute, want.second, want.wr_clock);
						$display("  actual   mode %0d sel %0d blink %0d %0d-%0d-%0d %0d:%0d:%0d wr %0d",
							got.mode, got.sel, got.blink, got.year, got.month, got.day,
							got.hour, got.minute, got.second, got.wr_clock);
					end
				end
			end
		end
	end

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		action      <= ACT_TICK;
		key_code    <= KEY_NONE;
		year_in     <= '0;
		month_in    <= '0;
		day_in      <= '0;
		hour_in     <= '0;
		minute_in   <= '0;
		second_in   <= '0;
		out_ready   <= 1'b0;
		mismatch_cnt = 0;
		result_cnt = 0;
		tick_cnt = 0;
		key_cnt = 0;
		read_cnt = 0;
		other_cnt = 0;
		strobe_cnt = 0;
		setting_cnt = 0;
		cal_mode = 1'b0;
		cal_sel = FLD_YEAR;
		cal_blink = 1'b0;
		cal_ticks = '0;
		cal_half = BLINK_RESET;
		cal_fld[FLD_YEAR] = 7'd0;
		cal_fld[FLD_MONTH] = 7'd1;
		cal_fld[FLD_DAY] = 7'd1;
		cal_fld[FLD_HOUR] = 7'd0;
		cal_fld[FLD_MINUTE] = 7'd0;
		cal_fld[FLD_SECOND] = 7'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_clock_readings();
		test_keys_in_show_mode();
		test_set_mode_walk();
		test_leap_february();
		test_random_sessions();

		drain_results();
		repeat (10) @(posedge clk);
		$display("covered %0d ticks, %0d key presses, %0d clock readings, %0d spare actions",
			tick_cnt, key_cnt, read_cnt, other_cnt);
		$display("over %0d blink period settings; %0d results checked, %0d write strobes",
			setting_cnt, result_cnt, strobe_cnt);
		if (mismatch_cnt == 0 && pending_results.size() == 0) begin
			$display("tb_calendar_time_setter_unit OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_cnt,
				pending_results.size());
			$display("tb_calendar_time_setter_unit NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cts_pkg.sv
rtl/core/cts_front.sv
rtl/core/cts_queue.sv
rtl/core/cts_back.sv
rtl/core/calendar_time_setter_unit.sv
tb/tb_calendar_time_setter_unit.sv
